FILE: hw/rtl/rvexu_pkg.sv
// Shared types and operation codes for the RV32I execute unit.
`default_nettype none

package rvexu_pkg;

    // Operation codes carried in the cmd field
    localparam logic [5:0] CMD_ADD         = 6'd0;
    localparam logic [5:0] CMD_ADDI        = 6'd10;
    localparam logic [5:0] CMD_SLTI        = 6'd11;
    localparam logic [5:0] CMD_SLTIU       = 6'd12;
    localparam logic [5:0] CMD_XORI        = 6'd13;
    localparam logic [5:0] CMD_ORI         = 6'd14;
    localparam logic [5:0] CMD_ANDI        = 6'd15;
    localparam logic [5:0] CMD_SLLI        = 6'd16;
    localparam logic [5:0] CMD_SRLI        = 6'd17;
    localparam logic [5:0] CMD_SRAI        = 6'd18;
    localparam logic [5:0] CMD_LOAD_FIRST  = 6'd19;
    localparam logic [5:0] CMD_LOAD_LAST   = 6'd23;
    localparam logic [5:0] CMD_STORE_FIRST = 6'd24;
    localparam logic [5:0] CMD_STORE_LAST  = 6'd26;
    localparam logic [5:0] CMD_BEQ         = 6'd27;
    localparam logic [5:0] CMD_BNE         = 6'd28;
    localparam logic [5:0] CMD_BLT         = 6'd29;
    localparam logic [5:0] CMD_BGE         = 6'd30;
    localparam logic [5:0] CMD_BLTU        = 6'd31;
    localparam logic [5:0] CMD_BGEU        = 6'd32;
    localparam logic [5:0] CMD_LUI         = 6'd33;
    localparam logic [5:0] CMD_AUIPC       = 6'd34;
    localparam logic [5:0] CMD_JAL         = 6'd35;
    localparam logic [5:0] CMD_JALR        = 6'd36;

    localparam int unsigned UPPER_SHIFT = 12;
    localparam logic [31:0] INSN_BYTES  = 32'd4;
    localparam logic [4:0]  SHAMT_MASK  = 5'h1F;

    // ALU function select
    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_SLL  = 4'd2,
        ALU_SLT  = 4'd3,
        ALU_SLTU = 4'd4,
        ALU_XOR  = 4'd5,
        ALU_SRL  = 4'd6,
        ALU_SRA  = 4'd7,
        ALU_OR   = 4'd8,
        ALU_AND  = 4'd9
    } alu_op_t;

    // One instruction beat into the unit
    typedef struct packed {
        logic [5:0]          cmd;
        logic signed [31:0]  src1_value;
        logic signed [31:0]  src2_value;
        logic signed [31:0]  immediate;
        logic [31:0]         instr_pc;
    } exu_in_t;

    // One result beat out of the unit
    typedef struct packed {
        logic signed [31:0]  alu_result;
        logic signed [31:0]  store_data;
        logic                redirect;
        logic [31:0]         target_pc;
        logic                reg_write;
        logic                mem_read;
        logic                mem_write;
        logic                mem_to_reg;
    } exu_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rvexu_alu.sv
// Combinational ALU, branch compare and target logic for one instruction.
`default_nettype none

module rvexu_alu
    import rvexu_pkg::*;
(
    input  wire exu_in_t instr,
    output exu_out_t     result
);

    logic [5:0]  cmd;
    logic [31:0] a;
    logic [31:0] s2;
    logic [31:0] imm;
    logic [31:0] pc;
    logic        is_imm_alu;
    logic        is_load;
    logic        is_store;
    logic        wr;
    logic [31:0] op_b;
    logic [4:0]  shamt;
    alu_op_t     op;
    logic [31:0] alu_val;
    logic        eq;
    logic        lt_s;
    logic        lt_u;
    logic        take;
    logic [31:0] sum_ab;
    logic [31:0] sum_ai;
    logic [31:0] pc_plus4;
    logic [31:0] pc_imm;
    logic [31:0] upper;

    assign cmd = instr.cmd;
    assign a   = instr.src1_value;
    assign s2  = instr.src2_value;
    assign imm = instr.immediate;
    assign pc  = instr.instr_pc;

    // Classify the command
    assign is_imm_alu = (cmd >= CMD_ADDI) && (cmd <= CMD_SRAI);
    assign is_load    = (cmd >= CMD_LOAD_FIRST) && (cmd <= CMD_LOAD_LAST);
    assign is_store   = (cmd >= CMD_STORE_FIRST) && (cmd <= CMD_STORE_LAST);
    assign wr         = (cmd <= CMD_LOAD_LAST) || ((cmd >= CMD_LUI) && (cmd <= CMD_JALR));

    // Pick the ALU function; immediate forms run add,slt,sltu,xor,or,and,sll,srl,sra
    always_comb
    begin
        op = ALU_ADD;
        if (cmd < CMD_ADDI)
        begin
            op = alu_op_t'(cmd[3:0]);
        end
        else
        begin
            case (cmd)
                CMD_ADDI:  op = ALU_ADD;
                CMD_SLTI:  op = ALU_SLT;
                CMD_SLTIU: op = ALU_SLTU;
                CMD_XORI:  op = ALU_XOR;
                CMD_ORI:   op = ALU_OR;
                CMD_ANDI:  op = ALU_AND;
                CMD_SLLI:  op = ALU_SLL;
                CMD_SRLI:  op = ALU_SRL;
                CMD_SRAI:  op = ALU_SRA;
                default:   op = ALU_ADD;
            endcase
        end
    end

    assign op_b  = is_imm_alu ? imm : s2;
    assign shamt = op_b[4:0] & SHAMT_MASK;

    // Evaluate the ALU function
    always_comb
    begin
        case (op)
            ALU_ADD:  alu_val = a + op_b;
            ALU_SUB:  alu_val = a - op_b;
            ALU_SLL:  alu_val = a << shamt;
            ALU_SLT:  alu_val = {31'd0, ($signed(a) < $signed(op_b))};
            ALU_SLTU: alu_val = {31'd0, (a < op_b)};
            ALU_XOR:  alu_val = a ^ op_b;
            ALU_SRL:  alu_val = a >> shamt;
            ALU_SRA:  alu_val = 32'($signed(a) >>> shamt);
            ALU_OR:   alu_val = a | op_b;
            ALU_AND:  alu_val = a & op_b;
            default:  alu_val = a + op_b;
        endcase
    end

    // Adders for addresses and targets
    assign sum_ab   = a + s2;
    assign sum_ai   = a + imm;
    assign pc_plus4 = pc + INSN_BYTES;
    assign pc_imm   = pc + imm;
    assign upper    = imm << UPPER_SHIFT;

    // Branch compare
    assign eq   = (a == s2);
    assign lt_s = ($signed(a) < $signed(s2));
    assign lt_u = (a < s2);

    always_comb
    begin
        case (cmd)
            CMD_BEQ:  take = eq;
            CMD_BNE:  take = !eq;
            CMD_BLT:  take = lt_s;
            CMD_BGE:  take = !lt_s;
            CMD_BLTU: take = lt_u;
            CMD_BGEU: take = !lt_u;
            CMD_JAL:  take = 1'b1;
            CMD_JALR: take = 1'b1;
            default:  take = 1'b0;
        endcase
    end

    // Assemble the result beat
    always_comb
    begin
        result            = '0;
        result.store_data = s2;
        result.redirect   = take;
        result.reg_write  = wr;
        result.mem_read   = is_load;
        result.mem_write  = is_store;
        result.mem_to_reg = is_load;
        result.target_pc  = pc_plus4;

        if ((cmd < CMD_ADDI) || is_imm_alu)
        begin
            result.alu_result = alu_val;
        end
        else if (is_load || is_store)
        begin
            result.alu_result = sum_ai;
        end
        else if (cmd == CMD_LUI)
        begin
            result.alu_result = upper;
        end
        else if (cmd == CMD_AUIPC)
        begin
            result.alu_result = pc + upper;
        end
        else if ((cmd == CMD_JAL) || (cmd == CMD_JALR))
        begin
            result.alu_result = pc_plus4;
        end
        else
        begin
            // branches, halt, nop and unused codes
            result.alu_result = sum_ab;
        end

        if (cmd == CMD_JALR)
        begin
            result.target_pc = {sum_ai[31:1], 1'b0};
        end
        else if (take)
        begin
            result.target_pc = pc_imm;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rv32i_execute_unit_core.sv
// Top level of the RV32I execute unit: input register, execute logic, result register.
`default_nettype none

// The unit takes one instruction beat on every cycle that start is high; busy
// stays low, so instructions may follow each other with no gap. A beat is
// captured in the input register, evaluated by the ALU and branch logic, and
// registered in the result register that drives done and result. Each result
// beat is shown on done and result for exactly one cycle. The receiver cannot
// stall the unit; it must take each result beat as it comes.
// Throughput is one instruction per cycle, set by the single register-to-
// register pass through the 32-bit adders and shifter.

module rv32i_execute_unit_core
    import rvexu_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    output logic         busy,
    input  wire exu_in_t instr,
    output logic         done,
    output exu_out_t     result
);

    logic     in_valid_reg;
    exu_in_t  in_reg;
    logic     out_valid_reg;
    exu_out_t out_reg;
    exu_out_t out_next;
    logic     accept;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Capture the incoming beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= instr;
        end
    end

    rvexu_alu u_alu (
        .instr  (in_reg),
        .result (out_next)
    );

    // Advance the result into the output register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign done   = out_valid_reg;
    assign result = out_reg;

    // Every accepted beat produces exactly one result
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted beat did not produce a result");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result beat without an accepted instruction");

    a_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.mem_read) |->
            (result.reg_write && result.mem_to_reg && !result.mem_write && !result.redirect))
        else $error("inconsistent load control flags");

endmodule

`default_nettype wire

FILE: verif/rv32i_execute_unit_core_tb.sv
// Self-checking testbench for the RV32I execute unit: directed and random instruction beats.
`default_nettype none

module rv32i_execute_unit_core_tb
    import rvexu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes that the package leaves unnamed
    localparam logic [5:0] CMD_SUB   = 6'd1;
    localparam logic [5:0] CMD_SLL   = 6'd2;
    localparam logic [5:0] CMD_SLT   = 6'd3;
    localparam logic [5:0] CMD_SLTU  = 6'd4;
    localparam logic [5:0] CMD_XOR   = 6'd5;
    localparam logic [5:0] CMD_SRL   = 6'd6;
    localparam logic [5:0] CMD_SRA   = 6'd7;
    localparam logic [5:0] CMD_OR    = 6'd8;
    localparam logic [5:0] CMD_AND   = 6'd9;
    localparam logic [5:0] CMD_LW    = CMD_LOAD_FIRST;
    localparam logic [5:0] CMD_LBU   = CMD_LOAD_LAST;
    localparam logic [5:0] CMD_SW    = CMD_STORE_FIRST;
    localparam logic [5:0] CMD_SB    = CMD_STORE_LAST;
    localparam logic [5:0] CMD_HALT  = 6'd37;
    localparam logic [5:0] CMD_NOP   = 6'd38;
    localparam logic [5:0] CMD_UNDEF_FIRST = 6'd39;
    localparam logic [5:0] CMD_UNDEF_LAST  = 6'd63;

    localparam int CLK_HALF    = 2;
    localparam int RESET_CYCLES = 9;
    localparam int MAX_GAP     = 10;
    localparam int RANDOM_BLOCKS = 12;
    localparam int BLOCK_ITEMS = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    exu_in_t   instr = '0;
    logic      done;
    exu_out_t  result;

    exu_out_t  pending_results[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        gaps_on = 1'b1;

    rv32i_execute_unit_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .instr  (instr),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ALU function on two 32-bit operands; shifts use the low 5 bits of b
    function automatic logic [31:0] alu_eval(alu_op_t fn, logic [31:0] a, logic [31:0] b);
        logic [4:0]         sh;
        logic signed [31:0] sa;
        sh = b[4:0] & SHAMT_MASK;
        sa = a;
        case (fn)
            ALU_ADD:  return a + b;
            ALU_SUB:  return a - b;
            ALU_SLL:  return a << sh;
            ALU_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            ALU_SLTU: return (a < b) ? 32'd1 : 32'd0;
            ALU_XOR:  return a ^ b;
            ALU_SRL:  return a >> sh;
            ALU_SRA:  return sa >>> sh;
            ALU_OR:   return a | b;
            ALU_AND:  return a & b;
            default:  return a + b;
        endcase
    endfunction

    // Map an immediate-form opcode onto its ALU function
    function automatic alu_op_t imm_alu_fn(logic [5:0] cmd);
        case (cmd)
            CMD_SLTI:  return ALU_SLT;
            CMD_SLTIU: return ALU_SLTU;
            CMD_XORI:  return ALU_XOR;
            CMD_ORI:   return ALU_OR;
            CMD_ANDI:  return ALU_AND;
            CMD_SLLI:  return ALU_SLL;
            CMD_SRLI:  return ALU_SRL;
            CMD_SRAI:  return ALU_SRA;
            default:   return ALU_ADD;
        endcase
    endfunction

    // Compute the result beat that one instruction must produce
    function automatic exu_out_t execute_instr(exu_in_t x);
        logic [31:0] a, b, imm, pc, res, tgt;
        logic        take, is_load, is_store, wr;
        exu_out_t    o;
        a   = x.src1_value;
        b   = x.src2_value;
        imm = x.immediate;
        pc  = x.instr_pc;
        tgt = pc + INSN_BYTES;
        take = 1'b0;
        is_load  = (x.cmd >= CMD_LOAD_FIRST) && (x.cmd <= CMD_LOAD_LAST);
        is_store = (x.cmd >= CMD_STORE_FIRST) && (x.cmd <= CMD_STORE_LAST);
        wr = (x.cmd <= CMD_LOAD_LAST) || ((x.cmd >= CMD_LUI) && (x.cmd <= CMD_JALR));
        if (x.cmd < CMD_ADDI)
        begin
            res = alu_eval(alu_op_t'(x.cmd[3:0]), a, b);
        end
        else if (x.cmd <= CMD_SRAI)
        begin
            res = alu_eval(imm_alu_fn(x.cmd), a, imm);
        end
        else if (is_load || is_store)
        begin
            res = a + imm;
        end
        else if ((x.cmd >= CMD_BEQ) && (x.cmd <= CMD_BGEU))
        begin
            res = a + b;
            case (x.cmd)
                CMD_BEQ:  take = (a == b);
                CMD_BNE:  take = (a != b);
                CMD_BLT:  take = ($signed(a) < $signed(b));
                CMD_BGE:  take = !($signed(a) < $signed(b));
                CMD_BLTU: take = (a < b);
                default:  take = (a >= b);
            endcase
            if (take)
                tgt = pc + imm;
        end
        else if (x.cmd == CMD_LUI)
        begin
            res = imm << UPPER_SHIFT;
        end
        else if (x.cmd == CMD_AUIPC)
        begin
            res = pc + (imm << UPPER_SHIFT);
        end
        else if (x.cmd == CMD_JAL)
        begin
            res  = pc + INSN_BYTES;
            take = 1'b1;
            tgt  = pc + imm;
        end
        else if (x.cmd == CMD_JALR)
        begin
            res  = pc + INSN_BYTES;
            take = 1'b1;
            tgt  = (a + imm) & ~32'd1;
        end
        else
        begin
            // halt, nop and undefined codes
            res = a + b;
        end
        o.alu_result = res;
        o.store_data = b;
        o.redirect   = take;
        o.target_pc  = tgt;
        o.reg_write  = wr;
        o.mem_read   = is_load;
        o.mem_write  = is_store;
        o.mem_to_reg = is_load;
        return o;
    endfunction

    function automatic exu_in_t make_instr(logic [5:0] cmd, logic [31:0] a, logic [31:0] b,
                                           logic [31:0] imm, logic [31:0] pc);
        exu_in_t x;
        x.cmd        = cmd;
        x.src1_value = a;
        x.src2_value = b;
        x.immediate  = imm;
        x.instr_pc   = pc;
        return x;
    endfunction

    // Operand values biased toward corners and small magnitudes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            1:       return $urandom_range(0, 40);
            2:       return 32'd0 - $urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_cmd();
        if ($urandom_range(0, 99) < 6)
            return 6'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
        return 6'($urandom_range(CMD_ADD, CMD_NOP));
    endfunction

    // Send one instruction beat; called at a rising edge, returns at the accepting edge
    task automatic send_instr(exu_in_t x);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        instr <= x;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(execute_instr(x));
    endtask

    // Drop start and hold until every expected beat has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        exu_out_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", result);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                cmp_field("alu_result", exp_r.alu_result, result.alu_result);
                cmp_field("store_data", exp_r.store_data, result.store_data);
                cmp_field("redirect", 32'(exp_r.redirect), 32'(result.redirect));
                cmp_field("target_pc", exp_r.target_pc, result.target_pc);
                cmp_field("reg_write", 32'(exp_r.reg_write), 32'(result.reg_write));
                cmp_field("mem_read", 32'(exp_r.mem_read), 32'(result.mem_read));
                cmp_field("mem_write", 32'(exp_r.mem_write), 32'(result.mem_write));
                cmp_field("mem_to_reg", 32'(exp_r.mem_to_reg), 32'(result.mem_to_reg));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Overflow, sign boundaries and shift amounts above 31
    task automatic test_reg_alu();
        send_instr(make_instr(CMD_ADD, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h100));
        send_instr(make_instr(CMD_SUB, 32'h8000_0000, 32'h1, 32'h0, 32'h104));
        send_instr(make_instr(CMD_SLL, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h108));
        send_instr(make_instr(CMD_SLT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h10C));
        send_instr(make_instr(CMD_SLTU, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h110));
        send_instr(make_instr(CMD_SRA, 32'h8000_0000, 32'h3F, 32'h0, 32'h114));
        send_instr(make_instr(CMD_SRL, 32'hFFFF_FFFF, 32'h21, 32'h0, 32'h118));
        send_instr(make_instr(CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h0, 32'h11C));
    endtask

    // Immediate forms, including unsigned compare against a negative immediate
    task automatic test_imm_alu();
        send_instr(make_instr(CMD_ADDI, 32'h0, 32'h1234, 32'hFFFF_FFFF, 32'h200));
        send_instr(make_instr(CMD_SLTIU, 32'h5, 32'h0, 32'hFFFF_FFFF, 32'h204));
        send_instr(make_instr(CMD_SLTI, 32'h5, 32'h0, 32'hFFFF_FFFF, 32'h208));
        send_instr(make_instr(CMD_SRAI, 32'h8000_0000, 32'h0, 32'h400, 32'h20C));
    endtask

    // Address wrap for loads and stores
    task automatic test_mem_access();
        send_instr(make_instr(CMD_LW, 32'hFFFF_FFFC, 32'hDEAD_BEEF, 32'h8, 32'h300));
        send_instr(make_instr(CMD_SB, 32'h7FFF_FFFF, 32'hCAFE_F00D, 32'h1, 32'h304));
    endtask

    // Taken and not-taken branches at the signed and unsigned boundaries
    task automatic test_branches();
        send_instr(make_instr(CMD_BEQ, 32'h1234, 32'h1234, 32'h10, 32'hFFFF_FFF8));
        send_instr(make_instr(CMD_BNE, 32'h1234, 32'h1234, 32'h10, 32'h400));
        send_instr(make_instr(CMD_BLT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 32'h8));
        send_instr(make_instr(CMD_BGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h20, 32'h408));
        send_instr(make_instr(CMD_BLTU, 32'h8000_0000, 32'h7FFF_FFFF, 32'h20, 32'h40C));
        send_instr(make_instr(CMD_BGEU, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000));
    endtask

    // Upper immediates and jumps, with an odd jalr sum
    task automatic test_upper_and_jumps();
        send_instr(make_instr(CMD_LUI, 32'h0, 32'h0, 32'hFFF_FFFFF, 32'h500));
        send_instr(make_instr(CMD_AUIPC, 32'h0, 32'h0, 32'h0000_0100, 32'hFFFF_FF00));
        send_instr(make_instr(CMD_JAL, 32'h0, 32'h0, 32'h10, 32'hFFFF_FFFC));
        send_instr(make_instr(CMD_JALR, 32'h1001, 32'h0, 32'h2, 32'h504));
    endtask

    // Halt, nop and undefined codes behave as nop
    task automatic test_halt_nop_undefined();
        send_instr(make_instr(CMD_HALT, 32'hFFFF_FFFF, 32'h1, 32'h40, 32'h600));
        send_instr(make_instr(CMD_NOP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h40, 32'h604));
        send_instr(make_instr(CMD_UNDEF_FIRST, 32'h1, 32'h2, 32'h40, 32'h608));
        send_instr(make_instr(CMD_UNDEF_LAST, 32'h8000_0000, 32'h8000_0000, 32'h40, 32'h60C));
    endtask

    // Random mix in blocks, some back to back, one drained pause in the middle
    task automatic test_random_mix();
        logic [5:0]  cmd;
        logic [31:0] a, b, pc;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (blk == RANDOM_BLOCKS / 2)
                wait_results_drained();
            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                cmd = pick_cmd();
                a = pick_word();
                b = pick_word();
                // equal operands make branch compares interesting
                if ((cmd >= CMD_BEQ) && (cmd <= CMD_BGEU) && ($urandom_range(0, 2) == 0))
                    b = a;
                pc = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                                 : $urandom;
                send_instr(make_instr(cmd, a, b, pick_word(), pc));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reg_alu();
        test_imm_alu();
        test_mem_access();
        test_branches();
        test_upper_and_jumps();
        test_halt_nop_undefined();
        wait_results_drained();
        test_random_mix();
        wait_results_drained();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
